// ===== rtl/cfvg_pkg.sv =====
// Shared types, constants and the arctangent table of the circle fan vertex generator.
package cfvg_pkg;

   localparam int SEG_W        = 13;
   localparam int MAX_SEGMENTS = 4096;
   localparam int PROD_W       = 30;
   localparam int DIV_W        = 47;
   localparam int PHASE_W      = 32;
   localparam int CORD_W       = 34;
   localparam int TRIG_STAGES  = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_ANGLE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CIRCLE_RADIUS = 2'd3;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [CORD_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [CORD_W-1:0] HALF_TURN    = 34'sd2147483648;

   // Per-item side information that travels beside the arithmetic.
   typedef struct packed {
      logic             idx_valid;
      logic             centre;
      logic             has_tri;
      logic [SEG_W-1:0] k;
   } meta_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/circle_fan_vertex_generator_core.sv =====
// Top level of the circle fan vertex generator: input stages, phase, position and output.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_vertex_index
//   rsp       out        rsp_valid/rsp_ready    rsp_pos_x .. rsp_index_valid
//   csr       in         csr_write_enable       csr_index, csr_write_data
//
// One item enters per cycle while the output is not stalled; the pipeline holds two input stages,
// 48 divider stages, a phase stage, 18 CORDIC stages, the radius multiply and the output register.
// The divider pipeline, one quotient bit a stage, sets the latency.
// Reset is synchronous and clears the valid bits and loads the register defaults.
// A stall at the output holds every stage in place; nothing is lost or repeated.
module circle_fan_vertex_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cfvg_pkg::SEG_W-1:0]          req_vertex_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [16:0]                  rsp_pos_x,
   output logic signed [16:0]                  rsp_pos_y,
   output logic [15:0]                         rsp_tex_u,
   output logic [15:0]                         rsp_tex_v,
   output logic [cfvg_pkg::SEG_W-1:0]          rsp_tri_a,
   output logic [cfvg_pkg::SEG_W-1:0]          rsp_tri_b,
   output logic                                rsp_tri_present,
   output logic                                rsp_index_valid,
   input  logic                                csr_write_enable,
   input  logic [cfvg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfvg_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import cfvg_pkg::*;

   logic [12:0] seg_ff;
   logic [15:0] start_ff;
   logic [16:0] sweep_ff;
   logic [15:0] radius_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff    <= 13'd32;
         start_ff  <= 16'd0;
         sweep_ff  <= 17'd65536;
         radius_ff <= 16'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_ff    <= csr_write_data[12:0];
            CSR_START_ANGLE:   start_ff  <= csr_write_data[15:0];
            CSR_SWEEP_ANGLE:   sweep_ff  <= csr_write_data[16:0];
            CSR_CIRCLE_RADIUS: radius_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Effective segment count, raised to three and capped.
   logic [SEG_W-1:0] seg_eff;
   always_comb begin
      if (seg_ff < 13'd3) begin
         seg_eff = 13'd3;
      end else if (seg_ff > 13'(MAX_SEGMENTS)) begin
         seg_eff = 13'(MAX_SEGMENTS);
      end else begin
         seg_eff = seg_ff;
      end
   end

   // The whole pipeline advances together whenever the output can move.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Stage one: classify the index.
   meta_type         m1_in;
   meta_type         m1_ff, m2_ff;
   logic [SEG_W-1:0] km1_ff;
   logic             v1_ff, v2_ff;
   logic [PROD_W-1:0] prod_ff;

   always_comb begin
      m1_in.k         = req_vertex_index;
      m1_in.centre    = req_vertex_index == '0;
      m1_in.idx_valid = {1'b0, req_vertex_index} <= ({1'b0, seg_eff} + 14'd1);
      m1_in.has_tri   = !m1_in.centre && (req_vertex_index <= seg_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         m1_ff   <= m1_in;
         km1_ff  <= req_vertex_index - 13'd1;
         m2_ff   <= m1_ff;
         prod_ff <= 30'(km1_ff) * 30'(sweep_ff);
      end
   end

   // Scaled, rounding-biased dividend for the per-vertex angle step.
   logic [DIV_W-1:0] dividend;
   assign dividend = {1'b0, prod_ff, 16'd0} + DIV_W'(seg_eff >> 1);

   logic             dv_valid;
   logic [DIV_W-1:0] quot;
   meta_type         dv_meta;

   cfvg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v2_ff),
      .dividend (dividend),
      .divisor  (seg_eff),
      .in_meta  (m2_ff),
      .out_valid(dv_valid),
      .quotient (quot),
      .out_meta (dv_meta)
   );

   // Phase stage: add the start angle, wrapping at one turn.
   logic [PHASE_W-1:0] phase_ff;
   logic               vp_ff;
   meta_type           mp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= dv_valid;
      end
      if (adv) begin
         phase_ff <= {start_ff, 16'd0} + quot[PHASE_W-1:0];
         mp_ff    <= dv_meta;
      end
   end

   logic               cv_valid;
   logic signed [16:0] cos_q, sin_q;
   meta_type           cv_meta;

   cfvg_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (vp_ff),
      .phase    (phase_ff),
      .in_meta  (mp_ff),
      .out_valid(cv_valid),
      .cos_q15  (cos_q),
      .sin_q15  (sin_q),
      .out_meta (cv_meta)
   );

   // Radius multiply.
   logic signed [33:0] px_ff, py_ff;
   logic signed [16:0] cm_ff, sm_ff;
   logic               vm_ff;
   meta_type           mm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= cv_valid;
      end
      if (adv) begin
         px_ff <= $signed({1'b0, radius_ff}) * cos_q;
         py_ff <= $signed({1'b0, radius_ff}) * sin_q;
         cm_ff <= cos_q;
         sm_ff <= sin_q;
         mm_ff <= cv_meta;
      end
   end

   // Output register: round the position, form the texture and triangle fields.
   logic signed [33:0] pxr, pyr;
   logic [17:0]        tu, tv;
   logic signed [16:0] ox_in, oy_in;
   logic [15:0]        ou_in, ov_in;
   logic [SEG_W-1:0]   oa_in, ob_in;
   logic               ot_in, oi_in;

   always_comb begin
      pxr   = (px_ff + 34'sd16384) >>> 15;
      pyr   = (py_ff + 34'sd16384) >>> 15;
      tu    = 18'($signed(cm_ff) + 18'sd32768);
      tv    = 18'($signed(sm_ff) + 18'sd32768);
      ox_in = pxr[16:0];
      oy_in = pyr[16:0];
      ou_in = (tu > 18'd65535) ? 16'hFFFF : tu[15:0];
      ov_in = (tv > 18'd65535) ? 16'hFFFF : tv[15:0];
      oa_in = mm_ff.has_tri ? mm_ff.k : '0;
      ob_in = mm_ff.has_tri ? mm_ff.k + 13'd1 : '0;
      ot_in = mm_ff.has_tri;
      oi_in = mm_ff.idx_valid;
      if (!mm_ff.idx_valid) begin
         ox_in = '0;
         oy_in = '0;
         ou_in = '0;
         ov_in = '0;
         oa_in = '0;
         ob_in = '0;
         ot_in = 1'b0;
      end else if (mm_ff.centre) begin
         ox_in = '0;
         oy_in = '0;
         ou_in = 16'd32768;
         ov_in = 16'd32768;
      end
   end

   logic               ov_ff;
   logic signed [16:0] ox_ff, oy_ff;
   logic [15:0]        ou_ff, ovt_ff;
   logic [SEG_W-1:0]   oa_ff, ob_ff;
   logic               ot_ff, oi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= vm_ff;
      end
      if (adv) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         ou_ff  <= ou_in;
         ovt_ff <= ov_in;
         oa_ff  <= oa_in;
         ob_ff  <= ob_in;
         ot_ff  <= ot_in;
         oi_ff  <= oi_in;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_pos_x       = ox_ff;
   assign rsp_pos_y       = oy_ff;
   assign rsp_tex_u       = ou_ff;
   assign rsp_tex_v       = ovt_ff;
   assign rsp_tri_a       = oa_ff;
   assign rsp_tri_b       = ob_ff;
   assign rsp_tri_present = ot_ff;
   assign rsp_index_valid = oi_ff;

   // An invalid index gives an all-zero item.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_valid) |->
         (rsp_pos_x == '0 && rsp_tex_u == '0 && rsp_tri_present == 1'b0))
      else $error("invalid index item not cleared");

   // A triangle belongs only to a valid arc vertex and names its successor.
   a_tri_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tri_present) |->
         (rsp_index_valid && rsp_tri_a != '0 && rsp_tri_b == rsp_tri_a + 13'd1))
      else $error("triangle fields inconsistent");

endmodule

// ===== rtl/cfvg_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cfvg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [cfvg_pkg::DIV_W-1:0]  dividend,
   input  logic [cfvg_pkg::SEG_W-1:0]  divisor,
   input  cfvg_pkg::meta_type          in_meta,
   output logic                        out_valid,
   output logic [cfvg_pkg::DIV_W-1:0]  quotient,
   output cfvg_pkg::meta_type          out_meta
);
   import cfvg_pkg::*;

   logic [SEG_W-1:0] rem_ff  [0:DIV_W];
   logic [DIV_W-1:0] nq_ff   [0:DIV_W];
   logic             val_ff  [0:DIV_W];
   meta_type         meta_ff [0:DIV_W];

   // The entry stage takes the dividend with a cleared remainder.
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]  <= '0;
         nq_ff[0]   <= dividend;
         meta_ff[0] <= in_meta;
      end
   end

   // Each stage shifts in one dividend bit and subtracts the divisor when it fits.
   for (genvar i = 0; i < DIV_W; i++) begin : g_stage
      logic [SEG_W:0]   trial;
      logic             fits;
      logic [SEG_W:0]   diff;
      logic [SEG_W-1:0] rem_in;
      logic [DIV_W-1:0] nq_in;

      always_comb begin
         trial  = {rem_ff[i], nq_ff[i][DIV_W-1]};
         fits   = trial >= {1'b0, divisor};
         diff   = trial - {1'b0, divisor};
         rem_in = fits ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
         nq_in  = {nq_ff[i][DIV_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i+1] <= 1'b0;
         end else if (adv) begin
            val_ff[i+1] <= val_ff[i];
         end
         if (adv) begin
            rem_ff[i+1]  <= rem_in;
            nq_ff[i+1]   <= nq_in;
            meta_ff[i+1] <= meta_ff[i];
         end
      end
   end

   assign out_valid = val_ff[DIV_W];
   assign quotient  = nq_ff[DIV_W];
   assign out_meta  = meta_ff[DIV_W];

   // A finished remainder is always below the divisor.
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (out_valid && divisor != '0) |-> (rem_ff[DIV_W] < divisor))
      else $error("divider remainder not below divisor");

endmodule

// ===== rtl/cfvg_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.15.
module cfvg_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [cfvg_pkg::PHASE_W-1:0]   phase,
   input  cfvg_pkg::meta_type             in_meta,
   output logic                           out_valid,
   output logic signed [16:0]             cos_q15,
   output logic signed [16:0]             sin_q15,
   output cfvg_pkg::meta_type             out_meta
);
   import cfvg_pkg::*;

   logic signed [CORD_W-1:0] x_ff    [0:TRIG_STAGES];
   logic signed [CORD_W-1:0] y_ff    [0:TRIG_STAGES];
   logic signed [CORD_W-1:0] z_ff    [0:TRIG_STAGES];
   logic                     flip_ff [0:TRIG_STAGES];
   logic                     val_ff  [0:TRIG_STAGES];
   meta_type                 meta_ff [0:TRIG_STAGES];

   // Fold the phase into the right half-plane, noting a sign flip.
   logic signed [CORD_W-1:0] z_raw;
   logic signed [CORD_W-1:0] z_in;
   logic                     flip_in;

   always_comb begin
      z_raw   = {{(CORD_W-PHASE_W){phase[PHASE_W-1]}}, phase};
      z_in    = z_raw;
      flip_in = 1'b0;
      if (z_raw > QUARTER_TURN) begin
         z_in    = z_raw - HALF_TURN;
         flip_in = 1'b1;
      end else if (z_raw < -QUARTER_TURN) begin
         z_in    = z_raw + HALF_TURN;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
         meta_ff[0] <= in_meta;
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
      logic signed [CORD_W-1:0] xs;
      logic signed [CORD_W-1:0] ys;
      logic signed [CORD_W-1:0] at;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         at = $signed({{(CORD_W-32){1'b0}}, atan_entry(5'(i))});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i+1] <= 1'b0;
         end else if (adv) begin
            val_ff[i+1] <= val_ff[i];
         end
         if (adv) begin
            if (!z_ff[i][CORD_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
            flip_ff[i+1] <= flip_ff[i];
            meta_ff[i+1] <= meta_ff[i];
         end
      end
   end

   // Undo the fold, round to Q1.15 and saturate.
   logic signed [CORD_W-1:0] xf, yf, xr, yr;
   logic signed [16:0]       cos_in, sin_in;
   logic signed [16:0]       cos_ff, sin_ff;
   logic                     oval_ff;
   meta_type                 ometa_ff;

   function automatic logic signed [16:0] sat_q15(input logic signed [CORD_W-1:0] v);
      logic signed [16:0] r;
      if (v > 34'sd32768) begin
         r = 17'sd32768;
      end else if (v < -34'sd32768) begin
         r = -17'sd32768;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   always_comb begin
      xf     = flip_ff[TRIG_STAGES] ? -x_ff[TRIG_STAGES] : x_ff[TRIG_STAGES];
      yf     = flip_ff[TRIG_STAGES] ? -y_ff[TRIG_STAGES] : y_ff[TRIG_STAGES];
      xr     = (xf + 34'sd16384) >>> 15;
      yr     = (yf + 34'sd16384) >>> 15;
      cos_in = sat_q15(xr);
      sin_in = sat_q15(yr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
      end else if (adv) begin
         oval_ff <= val_ff[TRIG_STAGES];
      end
      if (adv) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         ometa_ff <= meta_ff[TRIG_STAGES];
      end
   end

   assign out_valid = oval_ff;
   assign cos_q15   = cos_ff;
   assign sin_q15   = sin_ff;
   assign out_meta  = ometa_ff;

   // Rounded outputs stay within one unit either side.
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (cos_q15 <= 17'sd32768 && cos_q15 >= -17'sd32768))
      else $error("cosine out of range");

endmodule
